### src/dph_pkg.sv
`timescale 1ns / 1ps
package dph_pkg;

  // sequence store geometry
  localparam int MAX_ELEMENTS = 1024;
  localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

  // field widths
  localparam int LANE_W    = 30;
  localparam int IDX_W     = 11;
  localparam int FUNC_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CMP_W     = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  // modulus and barrett constant floor(2^(2*LANE_W) / HASH_MOD)
  localparam logic [LANE_W-1:0] HASH_MOD   = 30'd1000000007;
  localparam logic [LANE_W:0]   BARRETT_MU = 31'((64'd1 << (2 * LANE_W)) / 64'(HASH_MOD));

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SECOND = 1'b1;
  localparam logic [LANE_W-1:0]    BASE_FIRST_RST  = 30'd100000007;
  localparam logic [LANE_W-1:0]    BASE_SECOND_RST = 30'd200000033;

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [LANE_W-1:0] element_value;
    logic [IDX_W-1:0]  left_index;
    logic [IDX_W-1:0]  right_index;
  } in_item_t;

  typedef struct packed {
    logic [LANE_W-1:0] hash_first;
    logic [LANE_W-1:0] hash_second;
    logic              status;
  } out_item_t;

  // one stored entry, second lane in the upper half
  typedef struct packed {
    logic [LANE_W-1:0] second;
    logic [LANE_W-1:0] first;
  } lane_pair_t;

  // control that rides along the multiplier pipeline
  typedef struct packed {
    logic vld;
    logic last;
  } mm_tag_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_FETCH2,
    ST_ISSUE_B,
    ST_WAIT,
    ST_FINISH
  } state_t;

endpackage

### src/dph_modmul.sv
`timescale 1ns / 1ps
module dph_modmul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dph_pkg::mm_tag_t          in_tag,
  input  logic [dph_pkg::LANE_W-1:0] op_a,
  input  logic [dph_pkg::LANE_W-1:0] op_b,
  output dph_pkg::mm_tag_t          out_tag,
  output logic [dph_pkg::LANE_W-1:0] product
);
  import dph_pkg::*;

  localparam logic [LANE_W+1:0] MOD_X1 = {2'b00, HASH_MOD};
  localparam logic [LANE_W+1:0] MOD_X2 = {1'b0, HASH_MOD, 1'b0};

  mm_tag_t tag1_r, tag2_r, tag3_r, tag4_r;

  logic [2*LANE_W-1:0] prod_r;
  logic [2*LANE_W+1:0] quot_r;
  logic [LANE_W+1:0]   low_r;
  logic [LANE_W+1:0]   rem_r;
  logic [LANE_W-1:0]   res_r;

  logic [LANE_W:0]     q1;
  logic [LANE_W:0]     q3;
  logic [2*LANE_W:0]   qp_full;
  logic [LANE_W+1:0]   rem_nxt;
  logic [LANE_W+1:0]   sub1;
  logic [LANE_W+1:0]   sub2;
  logic [LANE_W-1:0]   res_nxt;

  // barrett estimate, off by at most two multiples of the modulus
  assign q1      = prod_r[2*LANE_W-1:LANE_W-1];
  assign q3      = quot_r[2*LANE_W+1:LANE_W+1];
  assign qp_full = q3 * HASH_MOD;
  assign rem_nxt = low_r - qp_full[LANE_W+1:0];

  assign sub1 = rem_r - MOD_X1;
  assign sub2 = rem_r - MOD_X2;

  always_comb begin
    if (rem_r >= MOD_X2) begin
      res_nxt = sub2[LANE_W-1:0];
    end else if (rem_r >= MOD_X1) begin
      res_nxt = sub1[LANE_W-1:0];
    end else begin
      res_nxt = rem_r[LANE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
      tag4_r <= '0;
    end else begin
      tag1_r <= in_tag;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
      tag4_r <= tag3_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    quot_r <= q1 * BARRETT_MU;
    low_r  <= prod_r[LANE_W+1:0];
    rem_r  <= rem_nxt;
    res_r  <= res_nxt;
  end

  assign out_tag = tag4_r;
  assign product = res_r;

endmodule

### src/double_polynomial_prefix_hash_unit.sv
`timescale 1ns / 1ps
// double polynomial prefix hash unit: keeps a sequence of up to MAX_ELEMENTS elements as
// prefix hashes in two lanes, each modulo 1000000007 with its own base (config registers
// base_first and base_second). func append extends the prefix as h*base+element and returns
// the new prefix pair, func query returns the hash of [left_index, right_index), func clear
// empties the sequence; a full store, a bad range or an unknown func answers zeros with
// status 1. one item is in work at a time. for an append or a query the first store read
// is registered at the accept edge, a further state issues the last multiply (old power
// of an append, left prefix of a query read through the same port), then a four-stage
// barrett modular multiplier per lane, the add or subtract that latches the hash, and a
// write back state that also loads the output register. clear, rejected items and empty
// queries go from accept straight to write back. the result sits in an output register,
// so the next item is taken while it waits; a finished item stalls only while that
// register is still full. prefix and power stores are single-port synchronous memories;
// no clearing pass is needed after reset
module double_polynomial_prefix_hash_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  dph_pkg::in_item_t            in_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output dph_pkg::out_item_t           out_item,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dph_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dph_pkg::LANE_W-1:0]    cfg_data
);
  import dph_pkg::*;

  // control state
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r;
  lane_pair_t        last_r;
  logic [LANE_W-1:0] base1_r, base2_r;
  logic              out_valid_r;
  logic              work_r;

  // item payload and intermediate values
  in_item_t   item_r;
  lane_pair_t hr_r;     // prefix at right end of a query
  lane_pair_t opnd_r;   // power operand for either flow
  lane_pair_t hnew_r;   // new prefix of an append
  lane_pair_t pnew_r;   // new power of an append
  out_item_t  res_r;
  out_item_t  out_item_r;

  // storage: one entry per element
  lane_pair_t pfx_mem [MAX_ELEMENTS];
  lane_pair_t pwr_mem [MAX_ELEMENTS];
  lane_pair_t pfx_rd_r, pwr_rd_r;

  logic              pfx_re, pwr_re;
  logic [ADDR_W-1:0] pfx_ra, pwr_ra;

  // multiplier lanes
  mm_tag_t           mm_issue;
  logic [LANE_W-1:0] mm_a1, mm_b1, mm_a2, mm_b2;
  mm_tag_t           mm_tag1, mm_tag2;
  logic [LANE_W-1:0] mm_res1, mm_res2;

  // decode of an arriving item
  logic             accept;
  logic [CMP_W-1:0] l_ext, r_ext, cnt_ext;
  logic [CMP_W-1:0] ra_right, ra_len, ra_cnt, ra_left;
  logic             is_append, is_query, is_clear;
  logic             full, range_bad, range_empty;
  logic             need_work, bad_item;
  logic             commit;

  // lane arithmetic
  logic [LANE_W-1:0] elem_red;
  logic [LANE_W:0]   elem_sub;
  logic [LANE_W:0]   sum1, sum2, sum1_sub, sum2_sub;
  logic [LANE_W-1:0] app1, app2;
  logic [LANE_W:0]   dif1, dif2;
  logic [LANE_W-1:0] qry1, qry2;
  lane_pair_t        hl;

  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign l_ext   = CMP_W'(in_item.left_index);
  assign r_ext   = CMP_W'(in_item.right_index);
  assign cnt_ext = CMP_W'(count_r);

  assign is_append   = (in_item.func == FUNC_APPEND);
  assign is_query    = (in_item.func == FUNC_QUERY);
  assign is_clear    = (in_item.func == FUNC_CLEAR);
  assign full        = (count_r == CNT_W'(MAX_ELEMENTS));
  assign range_bad   = (l_ext > r_ext) || (r_ext > cnt_ext);
  assign range_empty = (l_ext == r_ext);
  assign need_work   = (is_append && !full) || (is_query && !range_bad && !range_empty);
  assign bad_item    = (is_append && full) || (is_query && range_bad) ||
                       !(is_append || is_query || is_clear);

  // read addresses: right prefix and length power for a query, last power for an append
  assign ra_right = r_ext - CMP_W'(1);
  assign ra_len   = r_ext - l_ext - CMP_W'(1);
  assign ra_cnt   = cnt_ext - CMP_W'(1);
  assign ra_left  = CMP_W'(item_r.left_index) - CMP_W'(1);

  assign commit = (state_r == ST_FINISH) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = need_work ? ST_FETCH : ST_FINISH;
        end
      end
      ST_FETCH: begin
        state_nxt = (item_r.func == FUNC_APPEND) ? ST_ISSUE_B : ST_FETCH2;
      end
      ST_FETCH2:  state_nxt = ST_WAIT;
      ST_ISSUE_B: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (mm_tag1.vld && mm_tag1.last && mm_tag2.vld && mm_tag2.last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // left prefix of a query, zero for a range that starts at the beginning
  assign hl = (item_r.left_index == '0) ? '0 : pfx_rd_r;

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    pfx_re   = 1'b0;
    pwr_re   = 1'b0;
    pfx_ra   = ra_right[ADDR_W-1:0];
    pwr_ra   = is_append ? ra_cnt[ADDR_W-1:0] : ra_len[ADDR_W-1:0];
    mm_issue = '0;
    mm_a1    = last_r.first;
    mm_a2    = last_r.second;
    mm_b1    = base1_r;
    mm_b2    = base2_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        pfx_re   = in_valid && is_query;
        pwr_re   = in_valid;
      end
      ST_FETCH: begin
        if (item_r.func == FUNC_APPEND) begin
          // prefix times base, the element is added when it comes back
          mm_issue = '{vld: 1'b1, last: 1'b0};
        end else begin
          pfx_re = 1'b1;
          pfx_ra = ra_left[ADDR_W-1:0];
        end
      end
      ST_FETCH2: begin
        mm_issue = '{vld: 1'b1, last: 1'b1};
        mm_a1    = hl.first;
        mm_a2    = hl.second;
        mm_b1    = opnd_r.first;
        mm_b2    = opnd_r.second;
      end
      ST_ISSUE_B: begin
        mm_issue = '{vld: 1'b1, last: 1'b1};
        mm_a1    = opnd_r.first;
        mm_a2    = opnd_r.second;
      end
      ST_WAIT, ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  dph_modmul u_mm_first (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tag  (mm_issue),
    .op_a    (mm_a1),
    .op_b    (mm_b1),
    .out_tag (mm_tag1),
    .product (mm_res1)
  );

  dph_modmul u_mm_second (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tag  (mm_issue),
    .op_a    (mm_a2),
    .op_b    (mm_b2),
    .out_tag (mm_tag2),
    .product (mm_res2)
  );

  // append: product plus element, element may arrive unreduced
  assign elem_sub = {1'b0, item_r.element_value} - {1'b0, HASH_MOD};
  assign elem_red = elem_sub[LANE_W] ? item_r.element_value : elem_sub[LANE_W-1:0];
  assign sum1     = {1'b0, mm_res1} + {1'b0, elem_red};
  assign sum2     = {1'b0, mm_res2} + {1'b0, elem_red};
  assign sum1_sub = sum1 - {1'b0, HASH_MOD};
  assign sum2_sub = sum2 - {1'b0, HASH_MOD};
  assign app1     = sum1_sub[LANE_W] ? sum1[LANE_W-1:0] : sum1_sub[LANE_W-1:0];
  assign app2     = sum2_sub[LANE_W] ? sum2[LANE_W-1:0] : sum2_sub[LANE_W-1:0];

  // query: right prefix minus scaled left prefix
  assign dif1 = {1'b0, hr_r.first} - {1'b0, mm_res1};
  assign dif2 = {1'b0, hr_r.second} - {1'b0, mm_res2};
  assign qry1 = dif1[LANE_W] ? (dif1[LANE_W-1:0] + HASH_MOD) : dif1[LANE_W-1:0];
  assign qry2 = dif2[LANE_W] ? (dif2[LANE_W-1:0] + HASH_MOD) : dif2[LANE_W-1:0];

  // fsm and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
      work_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        work_r <= need_work;
      end
      if (commit) begin
        if (item_r.func == FUNC_APPEND && work_r) begin
          last_r  <= hnew_r;
          count_r <= count_r + CNT_W'(1);
        end else if (item_r.func == FUNC_CLEAR) begin
          last_r  <= '0;
          count_r <= '0;
        end
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base1_r <= BASE_FIRST_RST;
      base2_r <= BASE_SECOND_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BASE_FIRST:  base1_r <= cfg_data;
        CFG_BASE_SECOND: base2_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
      res_r  <= '{hash_first: '0, hash_second: '0,
                  status: (bad_item ? STATUS_ERR : STATUS_OK)};
    end
    if (state_r == ST_FETCH) begin
      hr_r <= pfx_rd_r;
      if (item_r.func == FUNC_APPEND && count_r == '0) begin
        opnd_r <= '{second: LANE_W'(1), first: LANE_W'(1)};
      end else begin
        opnd_r <= pwr_rd_r;
      end
    end
    if (mm_tag1.vld) begin
      if (item_r.func == FUNC_APPEND) begin
        if (mm_tag1.last) begin
          pnew_r <= '{second: mm_res2, first: mm_res1};
        end else begin
          hnew_r <= '{second: app2, first: app1};
          res_r  <= '{hash_first: app1, hash_second: app2, status: res_r.status};
        end
      end else begin
        res_r <= '{hash_first: qry1, hash_second: qry2, status: res_r.status};
      end
    end
    if (commit) begin
      out_item_r <= res_r;
    end
  end

  // prefix store
  always_ff @(posedge clk) begin
    if (commit && item_r.func == FUNC_APPEND && work_r) begin
      pfx_mem[count_r[ADDR_W-1:0]] <= hnew_r;
    end
    if (pfx_re) begin
      pfx_rd_r <= pfx_mem[pfx_ra];
    end
  end

  // power store
  always_ff @(posedge clk) begin
    if (commit && item_r.func == FUNC_APPEND && work_r) begin
      pwr_mem[count_r[ADDR_W-1:0]] <= pnew_r;
    end
    if (pwr_re) begin
      pwr_rd_r <= pwr_mem[pwr_ra];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### src/dph_checker.sv
`timescale 1ns / 1ps
module dph_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input dph_pkg::out_item_t out_item
);
  import dph_pkg::*;

  // a result that is not taken stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // an error answer carries zero hashes
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == STATUS_ERR |->
      out_item.hash_first == '0 && out_item.hash_second == '0)
    else $error("error result with nonzero hash");

  // both lanes are fully reduced
  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.hash_first < HASH_MOD && out_item.hash_second < HASH_MOD)
    else $error("hash not reduced");

  // one item in work at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while busy");

endmodule

bind double_polynomial_prefix_hash_unit dph_checker u_dph_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
